FILE: hw/rtl/rmpt_pkg.sv
// rmpt_pkg: shared constants and types for the rigid motion point transform unit
package rmpt_pkg;

   localparam int ANGLE_WIDTH = 32;
   localparam int FRAC_WIDTH  = 17;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int TRIG_WIDTH  = 32;
   localparam int CORDIC_XY_WIDTH = 34;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_START_ANGLE  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ANGULAR_RATE = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_OFFSET_X     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_OFFSET_Y     = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VELOCITY_X   = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VELOCITY_Y   = 3'd7;

   localparam logic signed [TRIG_WIDTH-1:0] ONE_Q30  = 32'sd1073741824;
   localparam logic signed [TRIG_WIDTH-1:0] GAIN_Q30 = 32'sd652032874;

   typedef logic [29:0] atan_entry_type;

   localparam atan_entry_type ATAN_TABLE [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

   typedef struct packed {
      logic adv;
      logic vld;
   } pipe_ctl_type;

endpackage

FILE: hw/rtl/rigid_motion_point_transform_unit.sv
// rigid_motion_point_transform_unit: rotate a point about a centre and translate it over time
// pipeline: CORDIC_STAGES + 6 register stages
// throughput: one point per cycle; the whole pipeline holds while a result waits under stall
// the cordic chain sets the latency, one rotation step per register stage
// reset clears all configuration registers to zero and empties the pipeline
module rigid_motion_point_transform_unit #(
   parameter int COORD_WIDTH   = 32,
   parameter int CORDIC_STAGES = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [COORD_WIDTH-1:0]            req_point_x,
   input  logic signed [COORD_WIDTH-1:0]            req_point_y,
   input  logic [rmpt_pkg::FRAC_WIDTH-1:0]          req_fraction,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [COORD_WIDTH-1:0]            rsp_moved_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_moved_y,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rmpt_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [(COORD_WIDTH > 32 ? COORD_WIDTH : 32)-1:0] csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int VW   = CW + 18;
   localparam int VTW  = CW + 2;
   localparam int HW   = DW - 16;
   localparam int HPW  = HW + rmpt_pkg::TRIG_WIDTH;
   localparam int LPW  = 17 + rmpt_pkg::TRIG_WIDTH;
   localparam int PW   = DW + rmpt_pkg::TRIG_WIDTH + 1;
   localparam int EW   = CW + 6;
   localparam int SIDE_W = 2 * DW + 2 * VTW;
   localparam int TW   = rmpt_pkg::TRIG_WIDTH;

   logic adv;
   rmpt_pkg::pipe_ctl_type cordic_ctl;

   // configuration registers
   logic signed [CW-1:0] center_x_ff, center_y_ff, offset_x_ff, offset_y_ff;
   logic signed [CW-1:0] velocity_x_ff, velocity_y_ff;
   logic [31:0]          start_angle_ff;
   logic signed [31:0]   angular_rate_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         start_angle_ff  <= '0;
         angular_rate_ff <= '0;
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
         velocity_x_ff   <= '0;
         velocity_y_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmpt_pkg::REG_CENTER_X:     center_x_ff     <= csr_wdata[CW-1:0];
            rmpt_pkg::REG_CENTER_Y:     center_y_ff     <= csr_wdata[CW-1:0];
            rmpt_pkg::REG_START_ANGLE:  start_angle_ff  <= csr_wdata[31:0];
            rmpt_pkg::REG_ANGULAR_RATE: angular_rate_ff <= csr_wdata[31:0];
            rmpt_pkg::REG_OFFSET_X:     offset_x_ff     <= csr_wdata[CW-1:0];
            rmpt_pkg::REG_OFFSET_Y:     offset_y_ff     <= csr_wdata[CW-1:0];
            rmpt_pkg::REG_VELOCITY_X:   velocity_x_ff   <= csr_wdata[CW-1:0];
            rmpt_pkg::REG_VELOCITY_Y:   velocity_y_ff   <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline holds only while a result waits
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: differences and fraction products
   logic signed [17:0]   frac_s;
   logic signed [DW-1:0] dx1_ff, dy1_ff;
   logic signed [49:0]   ang_prod_ff;
   logic signed [VW-1:0] vx_prod_ff, vy_prod_ff;
   logic                 v1_ff;

   assign frac_s = $signed({1'b0, req_fraction});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         dx1_ff      <= DW'(req_point_x) - DW'(center_x_ff);
         dy1_ff      <= DW'(req_point_y) - DW'(center_y_ff);
         ang_prod_ff <= 50'(angular_rate_ff) * 50'(frac_s);
         vx_prod_ff  <= VW'(velocity_x_ff) * VW'(frac_s);
         vy_prod_ff  <= VW'(velocity_y_ff) * VW'(frac_s);
      end
   end

   // stage 2: angle, quadrant split and rounded velocity terms
   logic signed [49:0]   ang_rnd;
   logic [31:0]          theta, theta_sh, resid;
   logic [1:0]           quad;
   logic signed [VW-1:0] vx_rnd, vy_rnd;
   logic signed [31:0]   z2_ff;
   logic [1:0]           q2_ff;
   logic [SIDE_W-1:0]    side2_ff;
   logic                 v2_ff;

   always_comb begin
      ang_rnd  = ang_prod_ff + 50'sd32768;
      theta    = start_angle_ff + ang_rnd[47:16];
      theta_sh = theta + 32'h2000_0000;
      quad     = theta_sh[31:30];
      resid    = theta - {quad, 30'd0};
      vx_rnd   = vx_prod_ff + VW'(32768);
      vy_rnd   = vy_prod_ff + VW'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         z2_ff    <= $signed(resid);
         q2_ff    <= quad;
         side2_ff <= {dx1_ff, dy1_ff, vx_rnd[VW-1:16], vy_rnd[VW-1:16]};
      end
   end

   // cordic chain
   logic                 vc;
   logic signed [TW-1:0] cs, sn;
   logic [SIDE_W-1:0]    sidec;

   assign cordic_ctl.adv = adv;
   assign cordic_ctl.vld = v2_ff;

   rmpt_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cordic_ctl),
      .in_z      (z2_ff),
      .in_q      (q2_ff),
      .in_side   (side2_ff),
      .out_valid (vc),
      .out_cos   (cs),
      .out_sin   (sn),
      .out_side  (sidec)
   );

   // stage m: partial products
   logic signed [DW-1:0]  dxc, dyc;
   logic signed [VTW-1:0] vtxc, vtyc;
   logic signed [HW-1:0]  dxh, dyh;
   logic signed [16:0]    dxl, dyl;

   assign {dxc, dyc, vtxc, vtyc} = sidec;
   assign dxh = dxc[DW-1:16];
   assign dyh = dyc[DW-1:16];
   assign dxl = $signed({1'b0, dxc[15:0]});
   assign dyl = $signed({1'b0, dyc[15:0]});

   logic signed [HPW-1:0] xc_h_ff, ys_h_ff, xs_h_ff, yc_h_ff;
   logic signed [LPW-1:0] xc_l_ff, ys_l_ff, xs_l_ff, yc_l_ff;
   logic signed [VTW-1:0] vtx_m_ff, vty_m_ff;
   logic                  vm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= vc;
      end
      if (adv) begin
         xc_h_ff  <= HPW'(dxh) * HPW'(cs);
         ys_h_ff  <= HPW'(dyh) * HPW'(sn);
         xs_h_ff  <= HPW'(dxh) * HPW'(sn);
         yc_h_ff  <= HPW'(dyh) * HPW'(cs);
         xc_l_ff  <= LPW'(dxl) * LPW'(cs);
         ys_l_ff  <= LPW'(dyl) * LPW'(sn);
         xs_l_ff  <= LPW'(dxl) * LPW'(sn);
         yc_l_ff  <= LPW'(dyl) * LPW'(cs);
         vtx_m_ff <= vtxc;
         vty_m_ff <= vtyc;
      end
   end

   // stage s: combine partial products
   logic signed [PW-1:0]  rx_s_ff, ry_s_ff;
   logic signed [VTW-1:0] vtx_s_ff, vty_s_ff;
   logic                  vs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (adv) begin
         vs_ff <= vm_ff;
      end
      if (adv) begin
         rx_s_ff  <= (PW'(xc_h_ff) <<< 16) + PW'(xc_l_ff)
                   - (PW'(ys_h_ff) <<< 16) - PW'(ys_l_ff);
         ry_s_ff  <= (PW'(xs_h_ff) <<< 16) + PW'(xs_l_ff)
                   + (PW'(yc_h_ff) <<< 16) + PW'(yc_l_ff);
         vtx_s_ff <= vtx_m_ff;
         vty_s_ff <= vty_m_ff;
      end
   end

   // stage f: round, translate, saturate
   localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

   logic signed [PW-1:0] rx_rnd, ry_rnd;
   logic signed [EW-1:0] sum_x, sum_y;
   logic signed [CW-1:0] out_x, out_y;
   logic signed [CW-1:0] moved_x_ff, moved_y_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      rx_rnd = rx_s_ff + PW'(32'sd536870912);
      ry_rnd = ry_s_ff + PW'(32'sd536870912);
      sum_x  = EW'($signed(rx_rnd[PW-1:30])) + EW'(center_x_ff) + EW'(offset_x_ff)
             + EW'(vtx_s_ff);
      sum_y  = EW'($signed(ry_rnd[PW-1:30])) + EW'(center_y_ff) + EW'(offset_y_ff)
             + EW'(vty_s_ff);
      if (sum_x > SAT_HI) begin
         out_x = SAT_HI[CW-1:0];
      end else if (sum_x < SAT_LO) begin
         out_x = SAT_LO[CW-1:0];
      end else begin
         out_x = sum_x[CW-1:0];
      end
      if (sum_y > SAT_HI) begin
         out_y = SAT_HI[CW-1:0];
      end else if (sum_y < SAT_LO) begin
         out_y = SAT_LO[CW-1:0];
      end else begin
         out_y = sum_y[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vs_ff;
      end
      if (adv) begin
         moved_x_ff <= out_x;
         moved_y_ff <= out_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_moved_x = moved_x_ff;
   assign rsp_moved_y = moved_y_ff;

   // input is held back only while a result transfer is pending
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // cordic outputs stay within the unit range
   assert property (@(posedge clock) disable iff (reset)
      vc |-> (cs <= rmpt_pkg::ONE_Q30 && cs >= -rmpt_pkg::ONE_Q30
              && sn <= rmpt_pkg::ONE_Q30 && sn >= -rmpt_pkg::ONE_Q30))
      else $error("sine or cosine out of unit range");

   // an unstalled pipeline moves the last stage into the result register
   assert property (@(posedge clock) disable iff (reset) adv |=> rsp_valid == $past(vs_ff))
      else $error("result valid lost or invented");

endmodule

FILE: hw/rtl/rmpt_cordic.sv
// rmpt_cordic: pipelined cordic sine and cosine with quadrant restore and sideband
module rmpt_cordic #(
   parameter int STAGES = 24,
   parameter int SIDE_W = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rmpt_pkg::pipe_ctl_type                    ctl,
   input  logic signed [31:0]                        in_z,
   input  logic [1:0]                                in_q,
   input  logic [SIDE_W-1:0]                         in_side,
   output logic                                      out_valid,
   output logic signed [rmpt_pkg::TRIG_WIDTH-1:0]    out_cos,
   output logic signed [rmpt_pkg::TRIG_WIDTH-1:0]    out_sin,
   output logic [SIDE_W-1:0]                         out_side
);

   localparam int XW = rmpt_pkg::CORDIC_XY_WIDTH;
   localparam int TW = rmpt_pkg::TRIG_WIDTH;

   logic signed [XW-1:0]  x_ff [STAGES];
   logic signed [XW-1:0]  y_ff [STAGES];
   logic signed [31:0]    z_ff [STAGES];
   logic [1:0]            q_ff [STAGES];
   logic [SIDE_W-1:0]     side_ff [STAGES];
   logic                  valid_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [XW-1:0] x_src, y_src, x_in, y_in;
      logic signed [31:0]   z_src, z_in, ang;
      logic [1:0]           q_src;
      logic [SIDE_W-1:0]    side_src;
      logic                 valid_src;

      if (i == 0) begin : g_first
         assign x_src     = XW'(rmpt_pkg::GAIN_Q30);
         assign y_src     = '0;
         assign z_src     = in_z;
         assign q_src     = in_q;
         assign side_src  = in_side;
         assign valid_src = ctl.vld;
      end else begin : g_next
         assign x_src     = x_ff[i-1];
         assign y_src     = y_ff[i-1];
         assign z_src     = z_ff[i-1];
         assign q_src     = q_ff[i-1];
         assign side_src  = side_ff[i-1];
         assign valid_src = valid_ff[i-1];
      end

      assign ang = $signed({2'b00, rmpt_pkg::ATAN_TABLE[i]});

      always_comb begin
         if (z_src >= 0) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - ang;
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl.adv) begin
            valid_ff[i] <= valid_src;
         end
         if (ctl.adv) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            q_ff[i]    <= q_src;
            side_ff[i] <= side_src;
         end
      end
   end

   logic signed [XW-1:0] x_cl, y_cl;
   logic signed [TW-1:0] xc, yc, cos_in, sin_in;
   logic signed [TW-1:0] cos_ff, sin_ff;
   logic [SIDE_W-1:0]    oside_ff;
   logic                 ovalid_ff;

   // clamp to unit range, then restore quadrant
   always_comb begin
      x_cl = x_ff[STAGES-1];
      y_cl = y_ff[STAGES-1];
      if (x_cl > XW'(rmpt_pkg::ONE_Q30)) begin
         x_cl = XW'(rmpt_pkg::ONE_Q30);
      end else if (x_cl < -XW'(rmpt_pkg::ONE_Q30)) begin
         x_cl = -XW'(rmpt_pkg::ONE_Q30);
      end
      if (y_cl > XW'(rmpt_pkg::ONE_Q30)) begin
         y_cl = XW'(rmpt_pkg::ONE_Q30);
      end else if (y_cl < -XW'(rmpt_pkg::ONE_Q30)) begin
         y_cl = -XW'(rmpt_pkg::ONE_Q30);
      end
      xc = TW'(x_cl);
      yc = TW'(y_cl);
      case (q_ff[STAGES-1])
         2'd0: begin
            cos_in = xc;
            sin_in = yc;
         end
         2'd1: begin
            cos_in = -yc;
            sin_in = xc;
         end
         2'd2: begin
            cos_in = -xc;
            sin_in = -yc;
         end
         default: begin
            cos_in = yc;
            sin_in = -xc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (ctl.adv) begin
         ovalid_ff <= valid_ff[STAGES-1];
      end
      if (ctl.adv) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         oside_ff <= side_ff[STAGES-1];
      end
   end

   assign out_valid = ovalid_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = oside_ff;

endmodule
